// ===== hw/rtl/hbcp_pkg.sv =====
// ----------------------------------------------------------------------------
// hbcp_pkg
// Shared types and constants for the Huffman byte code packer.
// ----------------------------------------------------------------------------
package hbcp_pkg;

	localparam int MAX_CODE_LEN = 8;
	localparam int LEN_W        = 4;
	localparam int BYTE_W       = 8;
	localparam int CNT_W        = 3;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_ENCODE = 2'd1,
		ACT_FLUSH  = 2'd2
	} action_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] code;
	} code_entry_t;

endpackage

// ===== hw/rtl/hbcp_sym_if.sv =====
// ----------------------------------------------------------------------------
// hbcp_sym_if
// Input channel: table loads, symbols to encode and flush requests.
// ----------------------------------------------------------------------------
interface hbcp_sym_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] symbol;
	logic [7:0] code_value;
	logic [3:0] code_length;

	modport source (output valid, action, symbol, code_value, code_length, input ready);
	modport sink   (input valid, action, symbol, code_value, code_length, output ready);
endinterface

// ===== hw/rtl/hbcp_byte_if.sv =====
// ----------------------------------------------------------------------------
// hbcp_byte_if
// Output channel: packed bytes with a final marker.
// ----------------------------------------------------------------------------
interface hbcp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] packed_byte;
	logic       final_res;

	modport source (output valid, packed_byte, final_res, input ready);
	modport sink   (input valid, packed_byte, final_res, output ready);
endinterface

// ===== hw/rtl/hbcp_code_table.sv =====
// ----------------------------------------------------------------------------
// hbcp_code_table
// Code table memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module hbcp_code_table #(
	parameter int DEPTH = 256,
	parameter int IDX_W = 8
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [IDX_W-1:0]            wr_idx,
	input  hbcp_pkg::code_entry_t       wr_entry,
	input  logic                        rd_en,
	input  logic [IDX_W-1:0]            rd_idx,
	output hbcp_pkg::code_entry_t       rd_entry
);
	import hbcp_pkg::*;

	code_entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry <= mem_q[rd_idx];
		end
	end
endmodule

// ===== hw/rtl/huffman_byte_code_packer_unit.sv =====
// ----------------------------------------------------------------------------
// huffman_byte_code_packer_unit
// Huffman encoder for byte symbols with codes up to 8 bits, packed LSB first.
// ----------------------------------------------------------------------------
// Takes one item per clock when the output side keeps up. An encode or flush
// item that emits a byte goes through these steps after acceptance: the code
// table memory is read into a registered stage, then the code is merged into
// the byte holder and the output register is loaded. Loads write the table
// at acceptance, so an encode right after a load of the same symbol sees the
// new entry. Table entries that were never loaded read back undefined.
// ----------------------------------------------------------------------------
module huffman_byte_code_packer_unit #(
	parameter int SYMBOL_COUNT = 256
) (
	input logic          clk,
	input logic          arst_n,
	hbcp_sym_if.sink     sym_stream,
	hbcp_byte_if.source  byte_stream
);
	import hbcp_pkg::*;

	localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

	// input side
	logic                  in_fire;
	logic                  sym_in_range;
	logic [LEN_W-1:0]      load_len;
	logic [2*BYTE_W-1:0]   load_mask;
	code_entry_t           load_entry;
	code_entry_t           rd_entry;

	// stage 1
	logic                  valid_s1;
	logic [1:0]            action_s1;
	logic                  in_range_s1;

	// holder and output
	logic [BYTE_W-1:0]     bits_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  out_valid_q;
	logic [BYTE_W-1:0]     out_byte_q;
	logic                  out_final_q;

	logic                  advance;
	logic                  s1_fire;
	logic [2*BYTE_W-1:0]   merged;
	logic [LEN_W-1:0]      total;
	logic                  emit;
	logic [BYTE_W-1:0]     emit_byte;
	logic                  emit_final;
	logic [BYTE_W-1:0]     bits_next;
	logic [CNT_W-1:0]      cnt_next;

	assign advance          = !out_valid_q || byte_stream.ready;
	assign s1_fire          = valid_s1 && advance;
	assign sym_stream.ready = !valid_s1 || advance;
	assign in_fire          = sym_stream.valid && sym_stream.ready;

	assign sym_in_range = {1'b0, sym_stream.symbol} < 9'(SYMBOL_COUNT);

	// clamp the length and mask stray code bits
	always_comb begin
		if (sym_stream.code_length > LEN_W'(MAX_CODE_LEN)) begin
			load_len = LEN_W'(MAX_CODE_LEN);
		end else begin
			load_len = sym_stream.code_length;
		end
		load_mask       = (16'd1 << load_len) - 16'd1;
		load_entry.len  = load_len;
		load_entry.code = sym_stream.code_value & load_mask[BYTE_W-1:0];
	end

	hbcp_code_table #(
		.DEPTH (SYMBOL_COUNT),
		.IDX_W (IDX_W)
	) u_table (
		.clk      (clk),
		.wr_en    (in_fire && sym_stream.action == ACT_LOAD && sym_in_range),
		.wr_idx   (sym_stream.symbol[IDX_W-1:0]),
		.wr_entry (load_entry),
		.rd_en    (in_fire),
		.rd_idx   (sym_stream.symbol[IDX_W-1:0]),
		.rd_entry (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sym_stream.ready) begin
			valid_s1 <= sym_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1   <= sym_stream.action;
			in_range_s1 <= sym_in_range;
		end
	end

	// merge the looked-up code into the holder
	always_comb begin
		merged     = {8'd0, bits_q} | ({8'd0, rd_entry.code} << cnt_q);
		total      = {1'b0, cnt_q} + rd_entry.len;
		emit       = 1'b0;
		emit_byte  = merged[BYTE_W-1:0];
		emit_final = 1'b0;
		bits_next  = bits_q;
		cnt_next   = cnt_q;
		case (action_s1)
			ACT_ENCODE: begin
				if (in_range_s1) begin
					cnt_next = total[CNT_W-1:0];
					if (total >= LEN_W'(BYTE_W)) begin
						emit      = 1'b1;
						bits_next = merged[2*BYTE_W-1:BYTE_W];
					end else begin
						bits_next = merged[BYTE_W-1:0];
					end
				end
			end
			ACT_FLUSH: begin
				if (cnt_q != '0) begin
					emit       = 1'b1;
					emit_byte  = bits_q;
					emit_final = 1'b1;
					bits_next  = '0;
					cnt_next   = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_fire) begin
				bits_q <= bits_next;
				cnt_q  <= cnt_next;
			end
			if (advance) begin
				out_valid_q <= s1_fire && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			out_byte_q  <= emit_byte;
			out_final_q <= emit_final;
		end
	end

	assign byte_stream.valid       = out_valid_q;
	assign byte_stream.packed_byte = out_byte_q;
	assign byte_stream.final_res   = out_final_q;

	// input stalls only behind a full, blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sym_stream.ready |-> (valid_s1 && out_valid_q && !byte_stream.ready))
		else $error("input stalled without output backpressure");

	// a flush always leaves the holder empty
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && action_s1 == ACT_FLUSH) |=> (cnt_q == '0 && bits_q == '0))
		else $error("holder not cleared by flush");

	// an item that emits nothing leaves the output empty
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && !emit) |=> !out_valid_q)
		else $error("result appeared without emit");

	// a new result only follows a stage-one item
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result without a preceding item");
endmodule

// ===== tb/huffman_byte_code_packer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// huffman_byte_code_packer_unit_tb
// Self-checking bench for the Huffman byte code packer. A
// predictor of the code table and byte holder runs alongside the block and
// queues the expected bytes. Each byte that leaves the block is compared with
// the oldest queued one. Directed table and encode corners come first, then
// random encode streams mixed with table reloads, unused actions and flushes.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module huffman_byte_code_packer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hbcp_pkg::*;

	localparam int NUM_SYMBOLS = 256;
	localparam int TARGET_ITEMS = 520;
	localparam int CYCLE_LIMIT = 300000;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] byte_val;
		logic       fin;
	} packed_result_t;

	logic clk = 1'b0;
	logic arst_n;

	hbcp_sym_if  sym_stream();
	hbcp_byte_if byte_stream();

	huffman_byte_code_packer_unit #(
		.SYMBOL_COUNT(NUM_SYMBOLS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sym_stream(sym_stream),
		.byte_stream(byte_stream)
	);

	// predictor state
	code_entry_t    code_book [NUM_SYMBOLS];
	logic [7:0]     holder_bits;
	logic [2:0]     holder_count;
	logic           holder_valid;
	int             loaded_syms[$];
	bit             sym_loaded [NUM_SYMBOLS];
	packed_result_t expected_bytes[$];

	int errors = 0;
	int items_sent = 0;
	int bytes_seen = 0;
	int finals_seen = 0;
	int cycle_count = 0;
	int send_calm = 0;
	int take_calm = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still expected", cycle_count,
				expected_bytes.size());
			$display("huffman_byte_code_packer_unit verification failed");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	function automatic void predict_item(input logic [1:0] act, input logic [7:0] sym,
		input logic [7:0] val, input logic [3:0] len);
		code_entry_t ent;
		logic [3:0]  clipped;
		logic [8:0]  mask;
		logic [15:0] merged;
		logic [4:0]  total;
		case (act)
			ACT_LOAD: begin
				if (sym < NUM_SYMBOLS) begin
					clipped = (len > MAX_CODE_LEN) ? 4'(MAX_CODE_LEN) : len;
					mask = (9'd1 << clipped) - 9'd1;
					ent.len = clipped;
					ent.code = val & mask[7:0];
					code_book[sym] = ent;
					if (!sym_loaded[sym]) begin
						sym_loaded[sym] = 1'b1;
						loaded_syms.push_back(int'(sym));
					end
				end
			end
			ACT_ENCODE: begin
				if (sym < NUM_SYMBOLS) begin
					ent = code_book[sym];
					merged = {8'h00, holder_bits} | ({8'h00, ent.code} << holder_count);
					total = {2'b00, holder_count} + {1'b0, ent.len};
					if (total >= 5'd8) begin
						expected_bytes.push_back('{byte_val: merged[7:0], fin: 1'b0});
						holder_bits = merged[15:8];
					end else begin
						holder_bits = merged[7:0];
					end
					// total stays below 16, so the low bits are the count left over
					holder_count = total[2:0];
					holder_valid = holder_count != 3'd0;
				end
			end
			ACT_FLUSH: begin
				if (holder_valid) begin
					expected_bytes.push_back('{byte_val: holder_bits, fin: 1'b1});
					holder_bits = 8'h00;
					holder_count = 3'd0;
					holder_valid = 1'b0;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// called and returns at a falling edge
	task automatic send_item(input logic [1:0] act, input logic [7:0] sym,
		input logic [7:0] val, input logic [3:0] len);
		int gap;
		if (send_calm > 0) begin
			gap = 0;
			send_calm--;
		end else begin
			gap = gap_len();
			if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 80);
		end
		if (gap > 0) begin
			sym_stream.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sym_stream.valid <= 1'b1;
		sym_stream.action <= act;
		sym_stream.symbol <= sym;
		sym_stream.code_value <= val;
		sym_stream.code_length <= len;
		do @(posedge clk); while (!sym_stream.ready);
		predict_item(act, sym, val, len);
		if (act != ACT_UNUSED) items_sent++;
		@(negedge clk);
	endtask

	task automatic send_encode_loaded();
		send_item(ACT_ENCODE, 8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]),
			8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
	endtask

	task automatic send_random_load();
		int r;
		logic [3:0] len;
		logic [7:0] sym;
		r = $urandom_range(0, 99);
		if (r < 10) len = 4'd0;
		else if (r < 22) len = 4'($urandom_range(9, 15));
		else len = 4'($urandom_range(1, 8));
		if (loaded_syms.size() > 0 && $urandom_range(0, 1) == 0)
			sym = 8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
		else
			sym = 8'($urandom_range(0, 255));
		send_item(ACT_LOAD, sym, 8'($urandom_range(0, 255)), len);
	endtask

	task automatic test_table_corners();
		send_item(ACT_LOAD, 8'd0, 8'hFF, 4'd8);
		// length above the maximum is clipped
		send_item(ACT_LOAD, 8'd255, 8'hA5, 4'd15);
		// stray bits above the length are dropped
		send_item(ACT_LOAD, 8'd85, 8'hFE, 4'd3);
		send_item(ACT_LOAD, 8'd170, 8'hFF, 4'd0);
		send_item(ACT_LOAD, 8'd1, 8'h01, 4'd1);
		send_item(ACT_LOAD, 8'd2, 8'h00, 4'd2);
	endtask

	task automatic test_encode_corners();
		send_item(ACT_ENCODE, 8'd0, 8'h00, 4'd0);
		send_item(ACT_ENCODE, 8'd85, 8'hFF, 4'hF);
		// zero-length code leaves the holder alone
		send_item(ACT_ENCODE, 8'd170, 8'h00, 4'd0);
		send_item(ACT_ENCODE, 8'd255, 8'h00, 4'd0);
		send_item(ACT_FLUSH, 8'd0, 8'h00, 4'd0);
		// nothing pending, so no byte
		send_item(ACT_FLUSH, 8'hFF, 8'hFF, 4'hF);
		send_item(ACT_UNUSED, 8'hFF, 8'hFF, 4'hF);
		send_item(ACT_ENCODE, 8'd1, 8'h00, 4'd0);
		send_item(ACT_ENCODE, 8'd2, 8'h00, 4'd0);
		send_item(ACT_ENCODE, 8'd1, 8'h00, 4'd0);
		send_item(ACT_ENCODE, 8'd2, 8'h00, 4'd0);
		send_item(ACT_ENCODE, 8'd1, 8'h00, 4'd0);
		send_item(ACT_ENCODE, 8'd0, 8'h00, 4'd0);
		send_item(ACT_FLUSH, 8'd0, 8'h00, 4'd0);
	endtask

	task automatic test_random_streams();
		int n_stream;
		int r;
		repeat (24) send_random_load();
		while (items_sent < TARGET_ITEMS) begin
			n_stream = $urandom_range(1, 40);
			for (int k = 0; k < n_stream; k++) begin
				r = $urandom_range(0, 99);
				if (r < 84) send_encode_loaded();
				else if (r < 91) send_random_load();
				else if (r < 96)
					send_item(ACT_UNUSED, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
				else send_item(ACT_FLUSH, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
			end
			if ($urandom_range(0, 9) != 0)
				send_item(ACT_FLUSH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					4'($urandom_range(0, 15)));
		end
	endtask

	// output side back-pressure
	initial begin
		int stall;
		stall = 0;
		byte_stream.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				byte_stream.ready <= 1'b0;
				stall--;
			end else begin
				byte_stream.ready <= 1'b1;
				if (take_calm > 0) begin
					take_calm--;
				end else begin
					stall = gap_len();
					if ($urandom_range(0, 49) == 0) take_calm = $urandom_range(20, 80);
				end
			end
		end
	end

	always @(posedge clk) begin
		packed_result_t want;
		if (arst_n && byte_stream.valid && byte_stream.ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte %02h final %0b", $time, byte_stream.packed_byte,
					byte_stream.final_res);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				bytes_seen++;
				if (want.fin) finals_seen++;
				if (byte_stream.packed_byte !== want.byte_val) begin
					$display("%0t: packed_byte expected %02h actual %02h", $time, want.byte_val,
						byte_stream.packed_byte);
					errors++;
				end
				if (byte_stream.final_res !== want.fin) begin
					$display("%0t: final_res expected %0b actual %0b", $time, want.fin,
						byte_stream.final_res);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		sym_stream.valid = 1'b0;
		sym_stream.action = ACT_LOAD;
		sym_stream.symbol = 8'h00;
		sym_stream.code_value = 8'h00;
		sym_stream.code_length = 4'd0;
		holder_bits = 8'h00;
		holder_count = 3'd0;
		holder_valid = 1'b0;
		for (int i = 0; i < NUM_SYMBOLS; i++) sym_loaded[i] = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_table_corners();
		test_encode_corners();
		test_random_streams();
		sym_stream.valid <= 1'b0;

		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d loads, encodes and flushes over %0d table entries", items_sent,
			loaded_syms.size());
		$display("checked %0d packed bytes, %0d of them final", bytes_seen, finals_seen);
		if (errors == 0) begin
			$display("huffman_byte_code_packer_unit verification clean");
		end else begin
			$display("huffman_byte_code_packer_unit verification failed");
		end
		$finish;
	end

endmodule
